// ----- design/b64_pkg.sv -----
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and the character lookup of the Base64 encoder.
// ----------------------------------------------------------------------------
package b64_pkg;

   localparam int GroupCountWidth      = 5;
   localparam int GroupsPerLineDefault = 19;
   localparam int QueueDepthDefault    = 2;
   localparam int CharsPerJob          = 4;
   localparam int CharIdxWidth         = $clog2(CharsPerJob);

   localparam logic [7:0] CharPad = 8'h3D;
   localparam logic [7:0] CharCr  = 8'h0D;
   localparam logic [7:0] CharLf  = 8'h0A;

   typedef enum logic [2:0] {
      PhaseFirst  = 3'b001,
      PhaseSecond = 3'b010,
      PhaseThird  = 3'b100
   } b64_phase_type;

   typedef struct packed {
      logic [CharsPerJob-1:0][7:0] chars;
      logic [CharIdxWidth-1:0]     last_idx;
   } b64_job_type;

   typedef struct packed {
      logic        valid;
      b64_job_type job;
   } b64_entry_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage

// ----- design/b64_if.sv -----
// ----------------------------------------------------------------------------
// b64_if
// Valid/ready stream interfaces for the byte input and the character output.
// ----------------------------------------------------------------------------
interface b64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

// ----- design/b64_front.sv -----
// ----------------------------------------------------------------------------
// b64_front
// Accepts bytes, tracks group phase, leftover bits and line position, and
// builds the character job of each byte.
// ----------------------------------------------------------------------------
module b64_front #(
   parameter int GROUPS_PER_LINE = b64_pkg::GroupsPerLineDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   b64_req_if.sink              req,
   input  logic                 queue_ready,
   output b64_pkg::b64_entry_type push
);
   import b64_pkg::*;

   b64_phase_type              phase_ff, phase_in;
   logic [3:0]                 leftover_ff, leftover_in;
   logic [GroupCountWidth-1:0] groups_ff, groups_in;
   logic [GroupCountWidth-1:0] groups_inc;
   logic                       line_full;
   logic                       accept;
   logic [7:0]                 b;
   b64_job_type                job;

   assign req.ready  = queue_ready;
   assign accept     = req.valid && queue_ready;
   assign b          = req.data_byte;
   assign groups_inc = groups_ff + GroupCountWidth'(1);
   assign line_full  = groups_inc >= GroupCountWidth'(GROUPS_PER_LINE);

   always_comb begin
      job         = '0;
      phase_in    = phase_ff;
      leftover_in = leftover_ff;
      groups_in   = groups_ff;
      unique case (phase_ff)
         PhaseSecond: begin
            job.chars[0] = b64_char({leftover_ff[1:0], b[7:4]});
            job.chars[1] = b64_char({b[3:0], 2'b00});
            job.chars[2] = CharPad;
            job.last_idx = req.last_byte ? CharIdxWidth'(2) : CharIdxWidth'(0);
            leftover_in  = b[3:0];
            phase_in     = PhaseThird;
         end
         PhaseThird: begin
            job.chars[0] = b64_char({leftover_ff, b[7:6]});
            job.chars[1] = b64_char(b[5:0]);
            job.chars[2] = CharCr;
            job.chars[3] = CharLf;
            job.last_idx = line_full ? CharIdxWidth'(3) : CharIdxWidth'(1);
            leftover_in  = 4'd0;
            phase_in     = PhaseFirst;
            groups_in    = line_full ? '0 : groups_inc;
         end
         default: begin
            job.chars[0] = b64_char(b[7:2]);
            job.chars[1] = b64_char({b[1:0], 4'b0000});
            job.chars[2] = CharPad;
            job.chars[3] = CharPad;
            job.last_idx = req.last_byte ? CharIdxWidth'(3) : CharIdxWidth'(0);
            leftover_in  = {2'b00, b[1:0]};
            phase_in     = PhaseSecond;
         end
      endcase
      if (req.last_byte) begin
         phase_in    = PhaseFirst;
         leftover_in = 4'd0;
         groups_in   = '0;
      end
   end

   assign push.valid = accept;
   assign push.job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhaseFirst;
         leftover_ff <= 4'd0;
         groups_ff   <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
         groups_ff   <= groups_in;
      end
   end

   a_groups_below_line : assert property (@(posedge clock) disable iff (reset)
      groups_ff < GroupCountWidth'(GROUPS_PER_LINE))
      else $error("group count reached line length");

   a_phase_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("group phase not one-hot");

   a_last_restarts : assert property (@(posedge clock) disable iff (reset)
      accept && req.last_byte |=>
         phase_ff == PhaseFirst && leftover_ff == 4'd0 && groups_ff == '0)
      else $error("state not cleared after last byte");

endmodule

// ----- design/b64_queue.sv -----
// ----------------------------------------------------------------------------
// b64_queue
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64_queue #(
   parameter int DEPTH = b64_pkg::QueueDepthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  b64_pkg::b64_entry_type push,
   input  logic                   pop,
   output logic                   space,
   output b64_pkg::b64_entry_type head
);
   import b64_pkg::*;

   localparam int PtrWidth   = $clog2(DEPTH);
   localparam int CountWidth = $clog2(DEPTH + 1);

   b64_job_type               entries_ff [DEPTH];
   logic [PtrWidth-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CountWidth-1:0]     count_ff, count_in;
   logic                      do_push;

   assign space      = count_ff != CountWidth'(DEPTH);
   assign do_push    = push.valid && space;
   assign head.valid = count_ff != '0;
   assign head.job   = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
         end
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("queue count out of range");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_empty_ptrs : assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers differ while empty");

endmodule

// ----- design/b64_back.sv -----
// ----------------------------------------------------------------------------
// b64_back
// Walks the characters of the head job and drives them out one per cycle,
// while the output port takes them, through an output register.
// ----------------------------------------------------------------------------
module b64_back (
   input  logic                   clock,
   input  logic                   reset,
   input  b64_pkg::b64_entry_type head,
   output logic                   pop,
   b64_rsp_if.source              rsp
);
   import b64_pkg::*;

   logic [CharIdxWidth-1:0] idx_ff;
   logic                    valid_ff;
   logic [7:0]              char_ff;
   logic                    last_ff;
   logic                    out_load;
   logic                    take;
   logic                    at_end;

   assign out_load = !valid_ff || rsp.ready;
   assign take     = out_load && head.valid;
   assign at_end   = idx_ff == head.job.last_idx;
   assign pop      = take && at_end;

   assign rsp.valid    = valid_ff;
   assign rsp.out_char = char_ff;
   assign rsp.out_last = last_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= head.job.chars[idx_ff];
         last_ff <= at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (out_load) begin
            valid_ff <= head.valid;
         end
         if (take) begin
            idx_ff <= at_end ? '0 : idx_ff + CharIdxWidth'(1);
         end
      end
   end

endmodule

// ----- design/base64_mime_encoder_core.sv -----
// ----------------------------------------------------------------------------
// base64_mime_encoder_core
// Streaming Base64 encoder with CR LF after every GROUPS_PER_LINE groups.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while the job queue has room; its characters
// (one to four, the last one flagged) leave the output register one per
// cycle while the output port takes them. After the byte is accepted, the
// first one passes through the job queue and then the output register. The
// output port sets the sustained rate: a byte yields one character for the
// first and second byte of a group, two for the third, four when a line
// break follows the group, four for a last byte that leaves a one-byte tail
// and three for one that leaves a two-byte tail.
module base64_mime_encoder_core #(
   parameter int GROUPS_PER_LINE = b64_pkg::GroupsPerLineDefault,
   parameter int QUEUE_DEPTH     = b64_pkg::QueueDepthDefault
) (
   input logic       clock,
   input logic       reset,
   b64_req_if.sink   req_chan,
   b64_rsp_if.source rsp_chan
);
   import b64_pkg::*;

   b64_entry_type push;
   b64_entry_type head;
   logic          space;
   logic          pop;

   b64_front #(
      .GROUPS_PER_LINE(GROUPS_PER_LINE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .queue_ready (space),
      .push        (push)
   );

   b64_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .space (space),
      .head  (head)
   );

   b64_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule
